@@ design/uf2bl_pkg.sv @@
// Package for the UF2 block loader: constants, codes and shared structs.
// Used by every module of the loader; depends on nothing.
`timescale 1ns / 1ps

package uf2bl_pkg;

	localparam int OFFSET_BITS       = 24;
	localparam int SPAN_BITS         = OFFSET_BITS + 1;
	localparam int BLOCK_WORDS       = 128;
	localparam int POS_BITS          = $clog2(BLOCK_WORDS);
	localparam int MAX_PAYLOAD_BYTES = 476;
	localparam int CFG_ADDR_BITS     = 2;
	localparam int CFG_DATA_BITS     = 32;
	localparam int SIZE_BITS         = 25;
	localparam int COUNT_BITS        = 16;
	localparam int BOFF_BITS         = POS_BITS + 2;

	localparam logic [31:0] MAGIC_START0 = 32'h0A32_4655;
	localparam logic [31:0] MAGIC_START1 = 32'h9E5D_5157;
	localparam logic [31:0] MAGIC_END    = 32'h0AB1_6F30;
	localparam int          FLAG_NOT_MAIN_BIT = 0;
	localparam int          FLAG_FAMILY_BIT   = 13;

	localparam logic [31:0]        RST_WINDOW_BASE     = 32'h1000_0000;
	localparam logic [SIZE_BITS-1:0] RST_WINDOW_SIZE   = SIZE_BITS'(1 << OFFSET_BITS);
	localparam logic [31:0]        RST_EXPECTED_FAMILY = 32'hE48B_FF56;

	localparam logic [POS_BITS-1:0] POS_MAGIC0  = POS_BITS'(0);
	localparam logic [POS_BITS-1:0] POS_MAGIC1  = POS_BITS'(1);
	localparam logic [POS_BITS-1:0] POS_FLAGS   = POS_BITS'(2);
	localparam logic [POS_BITS-1:0] POS_TARGET  = POS_BITS'(3);
	localparam logic [POS_BITS-1:0] POS_SIZE    = POS_BITS'(4);
	localparam logic [POS_BITS-1:0] POS_FAMILY  = POS_BITS'(7);
	localparam logic [POS_BITS-1:0] POS_PAYLOAD = POS_BITS'(8);
	localparam logic [POS_BITS-1:0] POS_LAST    = POS_BITS'(BLOCK_WORDS - 1);

	localparam logic [SIZE_BITS-1:0] WINDOW_CAP = SIZE_BITS'(1 << OFFSET_BITS);

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		CFG_WINDOW_BASE     = 2'd0,
		CFG_WINDOW_SIZE     = 2'd1,
		CFG_EXPECTED_FAMILY = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_STATUS = 2'd1,
		KIND_DONE   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SKIPPED   = 3'd1,
		ST_BAD_MAGIC = 3'd2,
		ST_TOO_LARGE = 3'd3,
		ST_OUTSIDE   = 3'd4,
		ST_NONE      = 3'd5
	} status_t;

	localparam logic [0:0] MODE_WORD = 1'b0;
	localparam logic [0:0] MODE_EOF  = 1'b1;

	typedef struct packed {
		logic [0:0]  mode;
		logic [31:0] word;
	} in_item_t;

	typedef struct packed {
		logic [31:0]          window_base;
		logic [SIZE_BITS-1:0] window_size;
		logic [31:0]          expected_family;
	} cfg_t;

	typedef struct packed {
		kind_t                 kind;
		logic [OFFSET_BITS-1:0] offset;
		logic [31:0]           data;
		logic [3:0]            byte_valid;
		status_t               status;
		logic                  family_warning;
		logic [COUNT_BITS-1:0] blocks_applied;
		logic [SPAN_BITS-1:0]  low_offset;
		logic [SPAN_BITS-1:0]  high_offset;
	} result_t;

	localparam int OUT_FIELD_BITS = OFFSET_BITS + 32 + 4 + 3 + 1 + COUNT_BITS + 2 * SPAN_BITS;
	localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

endpackage

@@ design/uf2bl_cfg.sv @@
// Configuration registers of the UF2 block loader (window and family).
// Depends on uf2bl_pkg.
`timescale 1ns / 1ps

module uf2bl_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [uf2bl_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
	input  logic [uf2bl_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	output uf2bl_pkg::cfg_t                      cfg
);
	import uf2bl_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_base     <= RST_WINDOW_BASE;
			cfg_q.window_size     <= RST_WINDOW_SIZE;
			cfg_q.expected_family <= RST_EXPECTED_FAMILY;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_WINDOW_BASE:     cfg_q.window_base     <= cfg_wdata;
				CFG_WINDOW_SIZE:     cfg_q.window_size     <= cfg_wdata[SIZE_BITS-1:0];
				CFG_EXPECTED_FAMILY: cfg_q.expected_family <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/uf2bl_in_reg.sv @@
// Input register stage of the UF2 block loader.
// Depends on uf2bl_pkg.
`timescale 1ns / 1ps

module uf2bl_in_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  uf2bl_pkg::in_item_t   s_item,
	input  logic                  advance,
	output logic                  valid_s1,
	output uf2bl_pkg::in_item_t   item_s1
);
	import uf2bl_pkg::*;

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= s_item;
		end
	end

endmodule

@@ design/uf2bl_parse.sv @@
// Block parser of the UF2 block loader: per-word state update and result build.
// Depends on uf2bl_pkg.
`timescale 1ns / 1ps

module uf2bl_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  uf2bl_pkg::cfg_t      cfg,
	input  logic                 valid_s1,
	input  uf2bl_pkg::in_item_t  item_s1,
	input  logic                 out_free,
	output logic                 advance,
	output logic                 res_valid,
	output uf2bl_pkg::result_t   res
);
	import uf2bl_pkg::*;

	logic [POS_BITS-1:0]   pos_q, pos_d;
	logic                  not_main_q, not_main_d;
	logic                  fam_present_q, fam_present_d;
	logic [31:0]           target_q, target_d;
	logic [31:0]           size_q, size_d;
	logic                  fam_mismatch_q, fam_mismatch_d;
	status_t               blk_err_q, blk_err_d;
	status_t               sticky_q, sticky_d;
	logic [COUNT_BITS-1:0] count_q, count_d;
	logic [SPAN_BITS-1:0]  low_q, low_d;
	logic [SPAN_BITS-1:0]  high_q, high_d;

	logic [SIZE_BITS-1:0]   eff_size;
	logic [32:0]            tgt_end;
	logic [32:0]            win_limit;
	logic [POS_BITS-1:0]    pos_m8;
	logic [BOFF_BITS-1:0]   boff;
	logic [31:0]            rem;
	logic [31:0]            rel_addr;
	logic [31:0]            wr_addr;
	logic [SPAN_BITS-1:0]   app_off;
	logic [SPAN_BITS-1:0]   app_end;
	status_t                last_st;
	logic                   is_word;
	logic [31:0]            w;

	assign w        = item_s1.word;
	assign is_word  = (item_s1.mode == MODE_WORD);
	assign eff_size = (cfg.window_size > WINDOW_CAP) ? WINDOW_CAP : cfg.window_size;
	assign tgt_end  = {1'b0, target_q} + {1'b0, w};
	assign win_limit = {1'b0, cfg.window_base} + 33'(eff_size);
	assign pos_m8   = pos_q - POS_PAYLOAD;
	assign boff     = {pos_m8, 2'b00};
	assign rem      = size_q - 32'(boff);
	assign rel_addr = target_q - cfg.window_base;
	assign wr_addr  = rel_addr + 32'(boff);
	assign app_off  = {1'b0, rel_addr[OFFSET_BITS-1:0]};
	assign app_end  = app_off + size_q[SPAN_BITS-1:0];

	always_comb begin
		if (blk_err_q == ST_BAD_MAGIC || w != MAGIC_END) begin
			last_st = ST_BAD_MAGIC;
		end else if (not_main_q) begin
			last_st = ST_SKIPPED;
		end else begin
			last_st = blk_err_q;
		end
	end

	always_comb begin
		pos_d          = pos_q;
		not_main_d     = not_main_q;
		fam_present_d  = fam_present_q;
		target_d       = target_q;
		size_d         = size_q;
		fam_mismatch_d = fam_mismatch_q;
		blk_err_d      = blk_err_q;
		sticky_d       = sticky_q;
		count_d        = count_q;
		low_d          = low_q;
		high_d         = high_q;
		res            = '0;
		res_valid      = 1'b0;

		if (!is_word) begin
			res.kind           = KIND_DONE;
			res.blocks_applied = count_q;
			if (sticky_q != ST_OK) begin
				res.status = sticky_q;
			end else if (count_q == '0) begin
				res.status = ST_NONE;
			end else begin
				res.status = ST_OK;
			end
			if (count_q != '0) begin
				res.low_offset  = low_q;
				res.high_offset = high_q;
			end
			res_valid      = 1'b1;
			pos_d          = '0;
			not_main_d     = 1'b0;
			fam_present_d  = 1'b0;
			target_d       = '0;
			size_d         = '0;
			fam_mismatch_d = 1'b0;
			blk_err_d      = ST_OK;
			sticky_d       = ST_OK;
			count_d        = '0;
			low_d          = '1;
			high_d         = '0;
		end else begin
			pos_d = pos_q + POS_BITS'(1);
			if (pos_q == POS_MAGIC0) begin
				blk_err_d      = (w != MAGIC_START0) ? ST_BAD_MAGIC : ST_OK;
				not_main_d     = 1'b0;
				fam_present_d  = 1'b0;
				fam_mismatch_d = 1'b0;
				target_d       = '0;
				size_d         = '0;
			end else if (pos_q == POS_MAGIC1) begin
				if (w != MAGIC_START1) begin
					blk_err_d = ST_BAD_MAGIC;
				end
			end else if (pos_q == POS_FLAGS) begin
				not_main_d    = w[FLAG_NOT_MAIN_BIT];
				fam_present_d = w[FLAG_FAMILY_BIT];
			end else if (pos_q == POS_TARGET) begin
				target_d = w;
			end else if (pos_q == POS_SIZE) begin
				size_d = w;
				if (blk_err_q == ST_OK && !not_main_q) begin
					if (w > 32'(MAX_PAYLOAD_BYTES)) begin
						blk_err_d = ST_TOO_LARGE;
					end else if (target_q < cfg.window_base || tgt_end > win_limit) begin
						blk_err_d = ST_OUTSIDE;
					end
				end
			end else if (pos_q == POS_FAMILY) begin
				fam_mismatch_d = fam_present_q && (w != cfg.expected_family);
			end else if (pos_q >= POS_PAYLOAD && pos_q < POS_LAST) begin
				if (sticky_q == ST_OK && blk_err_q == ST_OK && !not_main_q &&
				    32'(boff) < size_q) begin
					res.kind       = KIND_WRITE;
					res.offset     = wr_addr[OFFSET_BITS-1:0];
					res.data       = w;
					res.byte_valid = (rem >= 32'd4) ? 4'hF :
						4'((4'b0001 << rem[1:0]) - 4'b0001);
					res_valid      = 1'b1;
				end
			end else if (pos_q == POS_LAST) begin
				res.kind  = KIND_STATUS;
				res_valid = 1'b1;
				if (sticky_q != ST_OK) begin
					res.status = sticky_q;
				end else begin
					res.status         = last_st;
					res.family_warning = fam_mismatch_q && (last_st == ST_OK ||
						last_st == ST_TOO_LARGE || last_st == ST_OUTSIDE);
					if (last_st == ST_OK) begin
						if (app_off < low_q) begin
							low_d = app_off;
						end
						if (app_end > high_q) begin
							high_d = app_end;
						end
						if (count_q != '1) begin
							count_d = count_q + COUNT_BITS'(1);
						end
					end else if (last_st != ST_SKIPPED) begin
						sticky_d = last_st;
					end
				end
			end
		end
	end

	assign advance = valid_s1 && (!res_valid || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			not_main_q     <= 1'b0;
			fam_present_q  <= 1'b0;
			target_q       <= '0;
			size_q         <= '0;
			fam_mismatch_q <= 1'b0;
			blk_err_q      <= ST_OK;
			sticky_q       <= ST_OK;
			count_q        <= '0;
			low_q          <= '1;
			high_q         <= '0;
		end else if (advance) begin
			pos_q          <= pos_d;
			not_main_q     <= not_main_d;
			fam_present_q  <= fam_present_d;
			target_q       <= target_d;
			size_q         <= size_d;
			fam_mismatch_q <= fam_mismatch_d;
			blk_err_q      <= blk_err_d;
			sticky_q       <= sticky_d;
			count_q        <= count_d;
			low_q          <= low_d;
			high_q         <= high_d;
		end
	end

	a_write_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_WRITE |-> res.byte_valid != 4'h0)
		else $error("payload write with empty byte mask");

	a_sticky_holds: assert property (@(posedge clk) disable iff (!arst_n)
		sticky_q != ST_OK && !(advance && !is_word) |=> sticky_q == $past(sticky_q))
		else $error("sticky error changed before end of file");

	a_pos_steps: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_word |=> pos_q == $past(pos_q) + POS_BITS'(1))
		else $error("word position did not advance by one");

	a_no_write_after_error: assert property (@(posedge clk) disable iff (!arst_n)
		sticky_q != ST_OK && res_valid |-> res.kind != KIND_WRITE)
		else $error("payload write after sticky error");

endmodule

@@ design/uf2bl_out_reg.sv @@
// Result register of the UF2 block loader; packs the result onto the master side.
// Depends on uf2bl_pkg.
`timescale 1ns / 1ps

module uf2bl_out_reg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  load,
	input  uf2bl_pkg::result_t                    res,
	output logic                                  out_free,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [uf2bl_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	output logic [1:0]                            m_tuser
);
	import uf2bl_pkg::*;

	result_t res_s2;

	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && out_free) begin
			res_s2 <= res;
		end
	end

	assign m_tuser = res_s2.kind;
	assign m_tdata = OUT_DATA_BITS'({res_s2.high_offset, res_s2.low_offset,
		res_s2.blocks_applied, res_s2.family_warning, res_s2.status,
		res_s2.byte_valid, res_s2.data, res_s2.offset});

endmodule

@@ design/uf2_block_loader.sv @@
// Top level of the UF2 block loader: config registers, input stage, parser, result stage.
// Depends on uf2bl_pkg, uf2bl_cfg, uf2bl_in_reg, uf2bl_parse, uf2bl_out_reg.
`timescale 1ns / 1ps
//
// Usage:
//   Slave side carries the image one 32-bit little-endian word per beat in
//   s_tdata; s_tuser = 1 marks the end-of-file beat (its data is ignored).
//   Master side gives at most one word per input word: m_tuser 0 = tentative
//   payload write, 1 = block status (commit on status 0, discard otherwise),
//   2 = load done with status, applied count and touched offset range.
//   Configuration (window base, window size, expected family) is written
//   through cfg_we/cfg_addr/cfg_wdata while the block is idle.
// Timing:
//   One input word per cycle sustained while the master side takes each result.
//   A result reaches the master side through the input register, where the
//   accepted word is held, and then the result register, which the parser loads
//   with its result and which holds it until the receiver takes it. Words that give
//   no result still pass through the input register.
// Reset and stall:
//   arst_n clears all load state and loads the default configuration. When
//   m_tready is low with a result held, the parser stops on the next word that
//   has a result and s_tready falls; words with no result keep flowing.
//   End of file clears the load state for the next image.

module uf2_block_loader (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [31:0]                           s_tdata,  // word
	input  logic                                  s_tuser,  // mode
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// offset, data, byte_valid, status, family_warning, blocks_applied,
	// low_offset, high_offset, zero fill
	output logic [uf2bl_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	output logic [1:0]                            m_tuser,  // kind
	input  logic                                  cfg_we,
	input  logic [uf2bl_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
	input  logic [uf2bl_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
	import uf2bl_pkg::*;

	cfg_t     cfg;
	in_item_t s_item;
	in_item_t item_s1;
	logic     valid_s1;
	logic     advance;
	logic     out_free;
	logic     res_valid;
	result_t  res;

	assign s_item.mode = s_tuser;
	assign s_item.word = s_tdata;

	uf2bl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	uf2bl_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_item   (s_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	uf2bl_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.out_free  (out_free),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res)
	);

	uf2bl_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && res_valid),
		.res      (res),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
